### hw/rtl/bds_pkg.sv
// Shared types and constants for the battery display smoother.
`default_nettype none

package bds_pkg;

    localparam int unsigned LEVEL_BITS = 7;
    localparam int unsigned CFG_BITS   = 32;
    localparam int unsigned IDX_BITS   = 3;

    typedef logic [LEVEL_BITS-1:0] level_t;

    localparam level_t PERCENT_MAX = level_t'(100);

    // Charge status codes; any other code counts as discharging.
    localparam logic [1:0] STATUS_CHARGING = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_STABLE_WINDOW = 3'd0,
        CFG_STEP_INTERVAL = 3'd1,
        CFG_RESYNC_GAP    = 3'd2,
        CFG_JUMP_THRESH   = 3'd3,
        CFG_CRITICAL      = 3'd4,
        CFG_FULL_LEVEL    = 3'd5
    } cfg_index_t;

    localparam logic [CFG_BITS-1:0] STABLE_WINDOW_RST = 32'd15000;
    localparam logic [CFG_BITS-1:0] STEP_INTERVAL_RST = 32'd60000;
    localparam logic [CFG_BITS-1:0] RESYNC_GAP_RST    = 32'd60000;
    localparam level_t              JUMP_THRESH_RST   = 7'd5;
    localparam level_t              CRITICAL_RST      = 7'd5;
    localparam level_t              FULL_LEVEL_RST    = 7'd99;

endpackage

`default_nettype wire

### hw/rtl/bds_if.sv
// Request channels for gauge polls and for display results.
`default_nettype none

interface bds_poll_if;
    logic              valid;
    logic              ready;
    logic              read_ok;
    logic signed [7:0] raw_percent;
    logic [1:0]        power_status;
    logic [31:0]       now_ms;

    modport source (output valid, read_ok, raw_percent, power_status, now_ms, input ready);
    modport sink   (input valid, read_ok, raw_percent, power_status, now_ms, output ready);
endinterface

interface bds_shown_if;
    logic                         valid;
    logic                         ready;
    logic [bds_pkg::LEVEL_BITS-1:0] shown_percent;
    logic                         shown_valid;

    modport source (output valid, shown_percent, shown_valid, input ready);
    modport sink   (input valid, shown_percent, shown_valid, output ready);
endinterface

`default_nettype wire

### hw/rtl/battery_display_smoother.sv
// Top level of the battery display smoother.
`default_nettype none

// One poll request goes in, one display request comes out, in order. A poll is held
// in an input register, the whole smoothing decision and state update are
// combinational from it, and the result lands in an output register, from which its
// request is offered. One poll per cycle is sustained while results are taken, set
// by the single state-update stage. A poll is taken while a result waits as long as
// the input register is empty or moves on in that cycle. A failed read returns
// shown_valid low with percent zero and leaves all state untouched. Configuration
// writes are meant for idle periods only.
module battery_display_smoother #(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bds_pkg::IDX_BITS-1:0]  cfg_index,
    input  wire logic [bds_pkg::CFG_BITS-1:0]  cfg_wdata,
    bds_poll_if.sink                           poll,
    bds_shown_if.source                        shown
);

    localparam int unsigned CMP_BITS = (TIME_BITS > bds_pkg::CFG_BITS) ?
                                       TIME_BITS : bds_pkg::CFG_BITS;

    typedef logic [TIME_BITS-1:0] tm_t;
    typedef logic [CMP_BITS-1:0]  cmp_t;

    // Configuration registers.
    logic [bds_pkg::CFG_BITS-1:0] stable_window_reg;
    logic [bds_pkg::CFG_BITS-1:0] step_interval_reg;
    logic [bds_pkg::CFG_BITS-1:0] resync_gap_reg;
    bds_pkg::level_t              jump_thresh_reg;
    bds_pkg::level_t              critical_reg;
    bds_pkg::level_t              full_level_reg;

    // Input register.
    logic              s1_valid_reg;
    logic              s1_read_ok_reg;
    logic signed [7:0] s1_raw_reg;
    logic [1:0]        s1_status_reg;
    tm_t               s1_now_reg;

    // Smoothing state.
    bds_pkg::level_t display_reg, display_next;
    logic            display_known_reg, display_known_next;
    bds_pkg::level_t cand_reg, cand_next;
    logic            powered_seen_reg, powered_seen_next;
    tm_t             cand_since_reg, cand_since_next;
    tm_t             last_step_reg, last_step_next;
    tm_t             last_poll_reg, last_poll_next;
    logic            last_poll_known_reg, last_poll_known_next;

    // Output register.
    logic            out_valid_reg;
    bds_pkg::level_t out_percent_reg, out_percent_next;
    logic            out_ok_reg, out_ok_next;

    logic            advance;
    bds_pkg::level_t raw;
    logic            is_full;
    logic            powered;
    logic            resync_hit;
    logic            stable;
    logic            step_due;
    logic            go_up;
    logic            go_down;
    bds_pkg::level_t gap;
    tm_t             poll_age;
    tm_t             cand_age;
    tm_t             step_age;

    assign advance    = s1_valid_reg && (!out_valid_reg || shown.ready);
    assign poll.ready = !s1_valid_reg || advance;

    assign shown.valid         = out_valid_reg;
    assign shown.shown_percent = out_percent_reg;
    assign shown.shown_valid   = out_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_window_reg <= bds_pkg::STABLE_WINDOW_RST;
            step_interval_reg <= bds_pkg::STEP_INTERVAL_RST;
            resync_gap_reg    <= bds_pkg::RESYNC_GAP_RST;
            jump_thresh_reg   <= bds_pkg::JUMP_THRESH_RST;
            critical_reg      <= bds_pkg::CRITICAL_RST;
            full_level_reg    <= bds_pkg::FULL_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (bds_pkg::cfg_index_t'(cfg_index))
                bds_pkg::CFG_STABLE_WINDOW: stable_window_reg <= cfg_wdata;
                bds_pkg::CFG_STEP_INTERVAL: step_interval_reg <= cfg_wdata;
                bds_pkg::CFG_RESYNC_GAP:    resync_gap_reg    <= cfg_wdata;
                bds_pkg::CFG_JUMP_THRESH:   jump_thresh_reg   <= cfg_wdata[bds_pkg::LEVEL_BITS-1:0];
                bds_pkg::CFG_CRITICAL:      critical_reg      <= cfg_wdata[bds_pkg::LEVEL_BITS-1:0];
                bds_pkg::CFG_FULL_LEVEL:    full_level_reg    <= cfg_wdata[bds_pkg::LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (poll.ready)
            s1_valid_reg <= poll.valid;
    end

    always_ff @(posedge clk)
    begin
        if (poll.ready && poll.valid)
        begin
            s1_read_ok_reg <= poll.read_ok;
            s1_raw_reg     <= poll.raw_percent;
            s1_status_reg  <= poll.power_status;
            s1_now_reg     <= tm_t'(poll.now_ms);
        end
    end

    // Next state for the poll in the input register. The candidate and step
    // time are updated before the stability and step checks look at them.
    // Elapsed times wrap at the time width before they are compared.
    always_comb
    begin
        if (s1_raw_reg[7])
            raw = '0;
        else if (s1_raw_reg > 8'sd100)
            raw = bds_pkg::PERCENT_MAX;
        else
            raw = s1_raw_reg[bds_pkg::LEVEL_BITS-1:0];

        is_full = (s1_status_reg == bds_pkg::STATUS_FULL);
        powered = (s1_status_reg == bds_pkg::STATUS_CHARGING) || is_full;

        poll_age   = s1_now_reg - last_poll_reg;
        resync_hit = last_poll_known_reg && (cmp_t'(poll_age) >= cmp_t'(resync_gap_reg));

        display_next         = display_reg;
        display_known_next   = display_known_reg;
        cand_next            = cand_reg;
        powered_seen_next    = powered_seen_reg;
        cand_since_next      = cand_since_reg;
        last_step_next       = last_step_reg;
        last_poll_next       = last_poll_reg;
        last_poll_known_next = last_poll_known_reg;

        stable   = 1'b0;
        step_due = 1'b0;
        go_up    = 1'b0;
        go_down  = 1'b0;
        gap      = '0;
        cand_age = '0;
        step_age = '0;

        out_percent_next = '0;
        out_ok_next      = 1'b0;

        if (advance && s1_read_ok_reg)
        begin
            last_poll_next       = s1_now_reg;
            last_poll_known_next = 1'b1;

            if (!display_known_reg || resync_hit)
            begin
                display_next       = raw;
                display_known_next = 1'b1;
                cand_next          = raw;
                powered_seen_next  = powered;
                cand_since_next    = s1_now_reg;
                last_step_next     = s1_now_reg;
            end
            else
            begin
                if (powered != powered_seen_reg)
                begin
                    powered_seen_next = powered;
                    cand_next         = raw;
                    cand_since_next   = s1_now_reg;
                    last_step_next    = s1_now_reg;
                end
                else if (raw != cand_reg)
                begin
                    cand_next       = raw;
                    cand_since_next = s1_now_reg;
                end

                cand_age = s1_now_reg - cand_since_next;
                step_age = s1_now_reg - last_step_next;
                stable   = cmp_t'(cand_age) >= cmp_t'(stable_window_reg);
                step_due = cmp_t'(step_age) >= cmp_t'(step_interval_reg);
                go_up    = powered && (cand_next > display_reg);
                go_down  = !powered && (cand_next < display_reg);
                gap      = go_up ? (cand_next - display_reg) : (display_reg - cand_next);

                priority if (!powered && (raw <= critical_reg))
                begin
                    display_next   = raw;
                    last_step_next = s1_now_reg;
                end
                else if (is_full && (raw >= full_level_reg))
                begin
                    display_next   = bds_pkg::PERCENT_MAX;
                    last_step_next = s1_now_reg;
                end
                else
                begin
                    if (stable && (go_up || go_down))
                    begin
                        if (gap >= jump_thresh_reg)
                        begin
                            display_next   = raw;
                            last_step_next = s1_now_reg;
                        end
                        else if (step_due)
                        begin
                            display_next   = go_up ? (display_reg + 7'd1)
                                                   : (display_reg - 7'd1);
                            last_step_next = s1_now_reg;
                        end
                    end
                end
            end

            out_percent_next = display_next;
            out_ok_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_reg         <= '0;
            display_known_reg   <= 1'b0;
            cand_reg            <= '0;
            powered_seen_reg    <= 1'b0;
            cand_since_reg      <= '0;
            last_step_reg       <= '0;
            last_poll_reg       <= '0;
            last_poll_known_reg <= 1'b0;
        end
        else
        begin
            display_reg         <= display_next;
            display_known_reg   <= display_known_next;
            cand_reg            <= cand_next;
            powered_seen_reg    <= powered_seen_next;
            cand_since_reg      <= cand_since_next;
            last_step_reg       <= last_step_next;
            last_poll_reg       <= last_poll_next;
            last_poll_known_reg <= last_poll_known_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (shown.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_percent_reg <= out_percent_next;
            out_ok_reg      <= out_ok_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bds_checker.sv
// Port-level assertions for the battery display smoother, with its bind.
`default_nettype none

module bds_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           poll_valid,
    input wire logic                           poll_ready,
    input wire logic                           shown_req_valid,
    input wire logic                           shown_req_ready,
    input wire logic [bds_pkg::LEVEL_BITS-1:0] shown_percent,
    input wire logic                           shown_valid
);

    // A failed read always reports a zero percent.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        shown_req_valid && !shown_valid |-> shown_percent == '0)
        else $error("failed read reported a nonzero percent");

    // The smoothed display never leaves the percent range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        shown_req_valid |-> shown_percent <= bds_pkg::PERCENT_MAX)
        else $error("shown percent above one hundred");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        shown_req_valid && !shown_req_ready |=>
        shown_req_valid && $stable(shown_percent) && $stable(shown_valid))
        else $error("stalled result changed");

    // With nothing queued ahead, a free output means the block takes a poll.
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !shown_req_valid && $past(!poll_valid) |-> poll_ready)
        else $error("poll refused while the block was empty");

endmodule

bind battery_display_smoother bds_checker u_bds_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .poll_valid      (poll.valid),
    .poll_ready      (poll.ready),
    .shown_req_valid (shown.valid),
    .shown_req_ready (shown.ready),
    .shown_percent   (shown.shown_percent),
    .shown_valid     (shown.shown_valid)
);

`default_nettype wire
